@@ src/lmul_cosine_similarity_assert.svh @@
// Assertion macros for the reduced-precision cosine similarity block.
// Both expect clk and rst in the enclosing scope.
`ifndef LMUL_COSINE_SIMILARITY_ASSERT_SVH
`define LMUL_COSINE_SIMILARITY_ASSERT_SVH

// Same-cycle implication.
`define LCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmul_cs same-cycle check failed");

// Next-cycle implication.
`define LCS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmul_cs next-cycle check failed");

`endif

@@ src/lmul_cs_pkg.sv @@
`timescale 1ns / 1ps

package lmul_cs_pkg;

  localparam int unsigned MANT_W = 5;
  localparam int unsigned EXP_W  = 12;

  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] DEF_NAN   = 32'hFFC0_0000;

  localparam logic [MANT_W-1:0] MANT_RESET = 5'd8;

  localparam logic REG_MANT   = 1'b0;
  localparam logic REG_APPROX = 1'b1;

  typedef logic signed [EXP_W-1:0] exp_t;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0_0000_0000_0001,
    S_PROD      = 13'b0_0000_0000_0010,
    S_ADD       = 13'b0_0000_0000_0100,
    S_FMUL      = 13'b0_0000_0000_1000,
    S_SQRT_PREP = 13'b0_0000_0001_0000,
    S_SQRT_NORM = 13'b0_0000_0010_0000,
    S_SQRT_STEP = 13'b0_0000_0100_0000,
    S_DIVSET    = 13'b0_0000_1000_0000,
    S_DIV_STEP  = 13'b0_0001_0000_0000,
    S_NORM      = 13'b0_0010_0000_0000,
    S_PACK      = 13'b0_0100_0000_0000,
    S_DONE      = 13'b0_1000_0000_0000,
    S_OUT       = 13'b1_0000_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    OP_PMUL = 3'd0,
    OP_ACC  = 3'd1,
    OP_NMUL = 3'd2,
    OP_SQRT = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  function automatic logic [23:0] sig_of(logic [31:0] x);
    return {(x[30:23] != 8'd0), x[22:0]};
  endfunction

  function automatic logic [7:0] eff_field(logic [31:0] x);
    return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
  endfunction

  // Unbiased exponent of the significand's lsb.
  function automatic exp_t lsb_exp(logic [31:0] x);
    return exp_t'({4'b0, eff_field(x)}) - exp_t'(150);
  endfunction

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return (x[30:0] == INF_BITS[30:0]);
  endfunction

  function automatic logic is_zero(logic [31:0] x);
    return (x[30:0] == 31'd0);
  endfunction

  function automatic logic [24:0] approx_offset(logic [MANT_W-1:0] m);
    logic [24:0] off;
    case (m) inside
      5'd0:       off = 25'h100_0000;
      5'd1:       off = 25'h080_0000;
      5'd2:       off = 25'h040_0000;
      5'd3, 5'd4: off = 25'h020_0000;
      default:    off = 25'h010_0000;
    endcase
    return off;
  endfunction

endpackage

@@ src/lmul_cosine_similarity.sv @@
// Channel  | Signals                              | Direction
// ---------+--------------------------------------+----------
// in       | in_valid, in_ready, elem_a, elem_b,  | sink
//          | last_elem                            |
// out      | out_valid, out_ready, similarity     | source
// cfg      | cfg_we, cfg_addr, cfg_data           | sink
//
// One shared normalize/round unit serves every multiply, add, square root and divide.
// A pair takes three products and three accumulations, each normalized one to eight
// bits per cycle; a last pair adds the norm product, 26 root steps and 52 divide steps.
// Reset is synchronous; it clears the accumulators and loads the register defaults.
// in_ready is high only while idle; the result holds on out until taken.
`timescale 1ns / 1ps

`include "lmul_cosine_similarity_assert.svh"

module lmul_cosine_similarity (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               elem_a,
  input  logic [31:0]               elem_b,
  input  logic                      last_elem,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [31:0]               similarity,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [lmul_cs_pkg::MANT_W-1:0] cfg_data
);
  import lmul_cs_pkg::*;

  state_t state;
  op_t    op;

  logic [MANT_W-1:0] mant_bits;
  logic              use_approx;
  logic [31:0]       dot_sum, norm_a_sum, norm_b_sum;
  logic [31:0]       a_r, b_r, res;
  logic              last_r;
  logic [1:0]        k;
  logic [63:0]       s;
  exp_t              e;
  logic              sign, zero_sign;
  logic [5:0]        cnt;
  logic [24:0]       sq_mm;
  logic [51:0]       sq_n, sq_root;
  logic [25:0]       dv_r;
  logic [23:0]       dv_d;
  logic [51:0]       dv_q;

  // Reduced multiply
  logic [31:0] px, py;
  logic        prod_zero, prod_sign;
  logic [4:0]  mclamp;
  logic [22:0] fmask, fxa, fya;
  logic [63:0] p_sum;
  logic [47:0] p_mul;
  exp_t        p_e;

  always_comb begin
    unique case (k)
      2'd0:    begin px = a_r; py = b_r; end
      2'd1:    begin px = a_r; py = a_r; end
      default: begin px = b_r; py = b_r; end
    endcase
    prod_zero = is_zero(px) || is_zero(py);
    prod_sign = px[31] ^ py[31];
    mclamp    = (mant_bits > 5'd23) ? 5'd23 : mant_bits;
    fmask     = ~(23'h7F_FFFF >> mclamp);
    fxa       = px[22:0] & fmask;
    fya       = py[22:0] & fmask;
    p_sum     = 64'h100_0000 + 64'({fxa, 1'b0}) + 64'({fya, 1'b0})
              + 64'(approx_offset(mclamp));
    p_mul     = {1'b1, fxa} * {1'b1, fya};
    p_e       = exp_t'({4'b0, px[30:23]}) + exp_t'({4'b0, py[30:23]}) - exp_t'(254)
              - (use_approx ? exp_t'(24) : exp_t'(46));
  end

  // Accumulate
  logic [31:0] acc_sel, ad_big, ad_sml;
  logic [7:0]  ad_diff;
  logic [63:0] ad_big_w, ad_sml_w, ad_sml_al;
  logic        ad_sml_st;
  logic [63:0] ad_s;

  always_comb begin
    unique case (k)
      2'd0:    acc_sel = dot_sum;
      2'd1:    acc_sel = norm_a_sum;
      default: acc_sel = norm_b_sum;
    endcase
    if (res[30:0] >= acc_sel[30:0]) begin
      ad_big = res;
      ad_sml = acc_sel;
    end else begin
      ad_big = acc_sel;
      ad_sml = res;
    end
    ad_diff   = eff_field(ad_big) - eff_field(ad_sml);
    ad_big_w  = {10'd0, sig_of(ad_big), 30'd0};
    ad_sml_w  = {10'd0, sig_of(ad_sml), 30'd0};
    ad_sml_st = |(ad_sml_w & ~({64{1'b1}} << ad_diff));
    ad_sml_al = (ad_sml_w >> ad_diff) | {63'd0, ad_sml_st};
    ad_s      = (ad_big[31] == ad_sml[31]) ? (ad_big_w + ad_sml_al) : (ad_big_w - ad_sml_al);
  end

  // Norm product
  logic [47:0] fm_mul;
  logic        fm_sign;
  assign fm_mul  = sig_of(norm_a_sum) * sig_of(norm_b_sum);
  assign fm_sign = norm_a_sum[31] ^ norm_b_sum[31];

  // Square root
  logic [24:0] sq_mm_even;
  exp_t        sq_e_even;
  logic [51:0] sq_bit, sq_t, sq_root_next, sq_n_next;
  logic        sq_ge;

  always_comb begin
    sq_mm_even   = e[0] ? (sq_mm << 1) : sq_mm;
    sq_e_even    = e[0] ? (e - exp_t'(1)) : e;
    sq_bit       = 52'd1 << {cnt[4:0], 1'b0};
    sq_t         = sq_root + sq_bit;
    sq_ge        = sq_n >= sq_t;
    sq_root_next = sq_ge ? ((sq_root >> 1) + sq_bit) : (sq_root >> 1);
    sq_n_next    = sq_ge ? (sq_n - sq_t) : sq_n;
  end

  // Divide
  logic        dv_ge;
  logic [25:0] dv_rn;
  logic [51:0] dv_q_next;
  logic        dv_sign;

  assign dv_ge     = dv_r >= {2'b00, dv_d};
  assign dv_rn     = dv_ge ? (dv_r - {2'b00, dv_d}) : dv_r;
  assign dv_q_next = {dv_q[50:0], dv_ge};
  assign dv_sign   = dot_sum[31] ^ res[31];

  // Round and pack
  exp_t        pk_e;
  logic        pk_sub, pk_ovf, pk_lost, pk_g, pk_st, pk_up;
  logic [11:0] pk_sh;
  logic [63:0] pk_v;
  logic [11:0] pk_f;
  logic [24:0] pk_m;
  logic [31:0] pk_bits;
  logic [31:0] pk_res;

  always_comb begin
    pk_e    = e + exp_t'(190);
    pk_sub  = pk_e <= exp_t'(0);
    pk_sh   = 12'(exp_t'(1) - pk_e);
    pk_v    = pk_sub ? (s >> pk_sh) : s;
    pk_lost = pk_sub && (|(s & ~({64{1'b1}} << pk_sh)));
    pk_f    = pk_sub ? 12'd0 : 12'(pk_e - exp_t'(1));
    pk_ovf  = !pk_sub && (pk_e > exp_t'(255));
    pk_g    = pk_v[39];
    pk_st   = (|pk_v[38:0]) || pk_lost;
    pk_up   = pk_g && (pk_st || pk_v[40]);
    pk_m    = {1'b0, pk_v[63:40]} + {24'd0, pk_up};
    pk_bits = {1'b0, pk_f[7:0], 23'd0} + {7'd0, pk_m};
    if (pk_ovf || (pk_bits >= INF_BITS)) begin
      pk_res = {sign, INF_BITS[30:0]};
    end else begin
      pk_res = {sign, pk_bits[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op         <= OP_PMUL;
      k          <= 2'd0;
      mant_bits  <= MANT_RESET;
      use_approx <= 1'b1;
      dot_sum    <= 32'd0;
      norm_a_sum <= 32'd0;
      norm_b_sum <= 32'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MANT:   mant_bits  <= cfg_data;
          REG_APPROX: use_approx <= cfg_data[0];
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_r    <= elem_a;
            b_r    <= elem_b;
            last_r <= last_elem;
            k      <= 2'd0;
            state  <= S_PROD;
          end
        end
        S_PROD: begin
          op <= OP_PMUL;
          if (prod_zero) begin
            res   <= {prod_sign, 31'd0};
            state <= S_DONE;
          end else begin
            s         <= use_approx ? p_sum : 64'(p_mul);
            e         <= p_e;
            sign      <= prod_sign;
            zero_sign <= prod_sign;
            state     <= S_NORM;
          end
        end
        S_ADD: begin
          op <= OP_ACC;
          if (is_nan(res) || is_nan(acc_sel) ||
              (is_inf(res) && is_inf(acc_sel) && (res[31] != acc_sel[31]))) begin
            res   <= DEF_NAN;
            state <= S_DONE;
          end else if (is_inf(res)) begin
            state <= S_DONE;
          end else if (is_inf(acc_sel)) begin
            res   <= acc_sel;
            state <= S_DONE;
          end else begin
            s         <= ad_s;
            e         <= lsb_exp(ad_big) - exp_t'(30);
            sign      <= ad_big[31];
            zero_sign <= res[31] & acc_sel[31];
            state     <= S_NORM;
          end
        end
        S_FMUL: begin
          op <= OP_NMUL;
          if (is_nan(norm_a_sum) || is_nan(norm_b_sum) ||
              (is_inf(norm_a_sum) && is_zero(norm_b_sum)) ||
              (is_zero(norm_a_sum) && is_inf(norm_b_sum))) begin
            res   <= DEF_NAN;
            state <= S_DONE;
          end else if (is_inf(norm_a_sum) || is_inf(norm_b_sum)) begin
            res   <= {fm_sign, INF_BITS[30:0]};
            state <= S_DONE;
          end else if (is_zero(norm_a_sum) || is_zero(norm_b_sum)) begin
            res   <= {fm_sign, 31'd0};
            state <= S_DONE;
          end else begin
            s         <= 64'(fm_mul);
            e         <= lsb_exp(norm_a_sum) + lsb_exp(norm_b_sum);
            sign      <= fm_sign;
            zero_sign <= fm_sign;
            state     <= S_NORM;
          end
        end
        S_SQRT_PREP: begin
          op <= OP_SQRT;
          if (res[30:23] == 8'hFF) begin
            if (res[22:0] != 23'd0) begin
              res <= res | 32'h0040_0000;
            end else if (res[31]) begin
              res <= QNAN_BITS;
            end
            state <= S_DONE;
          end else if (is_zero(res)) begin
            state <= S_DONE;
          end else if (res[31]) begin
            res   <= QNAN_BITS;
            state <= S_DONE;
          end else begin
            sq_mm <= {1'b0, sig_of(res)};
            e     <= lsb_exp(res);
            state <= S_SQRT_NORM;
          end
        end
        S_SQRT_NORM: begin
          if (!sq_mm[23]) begin
            sq_mm <= sq_mm << 1;
            e     <= e - exp_t'(1);
          end else begin
            sq_n    <= 52'(sq_mm_even) << 26;
            sq_root <= 52'd0;
            e       <= sq_e_even;
            cnt     <= 6'd25;
            state   <= S_SQRT_STEP;
          end
        end
        S_SQRT_STEP: begin
          sq_root <= sq_root_next;
          sq_n    <= sq_n_next;
          cnt     <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            s         <= 64'({sq_root_next, (sq_n_next != 52'd0)});
            e         <= (e >>> 1) - exp_t'(14);
            sign      <= 1'b0;
            zero_sign <= 1'b0;
            state     <= S_NORM;
          end
        end
        S_DIVSET: begin
          op         <= OP_DIV;
          dot_sum    <= 32'd0;
          norm_a_sum <= 32'd0;
          norm_b_sum <= 32'd0;
          state      <= S_OUT;
          if (is_zero(res)) begin
            if (is_zero(dot_sum) || is_nan(dot_sum)) begin
              res <= QNAN_BITS;
            end else begin
              res <= {dv_sign, INF_BITS[30:0]};
            end
          end else if (is_nan(dot_sum) || is_nan(res) ||
                       (is_inf(dot_sum) && is_inf(res))) begin
            res <= DEF_NAN;
          end else if (is_inf(dot_sum)) begin
            res <= {dv_sign, INF_BITS[30:0]};
          end else if (is_inf(res) || is_zero(dot_sum)) begin
            res <= {dv_sign, 31'd0};
          end else begin
            dv_r      <= {2'b00, sig_of(dot_sum)};
            dv_d      <= sig_of(res);
            dv_q      <= 52'd0;
            cnt       <= 6'd51;
            e         <= lsb_exp(dot_sum) - lsb_exp(res) - exp_t'(52);
            sign      <= dv_sign;
            zero_sign <= dv_sign;
            state     <= S_DIV_STEP;
          end
        end
        S_DIV_STEP: begin
          dv_q <= dv_q_next;
          dv_r <= dv_rn << 1;
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            s     <= 64'({dv_q_next, (dv_rn != 26'd0)});
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (s == 64'd0) begin
            res   <= {zero_sign, 31'd0};
            state <= S_DONE;
          end else if (s[63]) begin
            state <= S_PACK;
          end else if (s[63:56] == 8'd0) begin
            s <= s << 8;
            e <= e - exp_t'(8);
          end else begin
            s <= s << 1;
            e <= e - exp_t'(1);
          end
        end
        S_PACK: begin
          res   <= pk_res;
          state <= S_DONE;
        end
        S_DONE: begin
          unique case (op)
            OP_PMUL: state <= S_ADD;
            OP_ACC: begin
              unique case (k)
                2'd0:    dot_sum    <= res;
                2'd1:    norm_a_sum <= res;
                default: norm_b_sum <= res;
              endcase
              if (k != 2'd2) begin
                k     <= k + 2'd1;
                state <= S_PROD;
              end else if (last_r) begin
                state <= S_FMUL;
              end else begin
                state <= S_IDLE;
              end
            end
            OP_NMUL: state <= S_SQRT_PREP;
            OP_SQRT: state <= S_DIVSET;
            OP_DIV:  state <= S_OUT;
            default: state <= S_IDLE;
          endcase
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign similarity = res;

  `LCS_ASSERT_IMP(a_out_excl, out_valid, !in_ready)
  `LCS_ASSERT_IMP(a_acc_clear, out_valid, (dot_sum == 32'd0) && (norm_a_sum == 32'd0) && (norm_b_sum == 32'd0))
  `LCS_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready && !out_valid)

endmodule
